@@ design/qrs_pkg.sv @@
// Shared case codes for the quadratic root solver.
package qrs_pkg;

  typedef enum logic [2:0] {
    CASE_ALL_X    = 3'd0,
    CASE_NONE     = 3'd1,
    CASE_LINEAR   = 3'd2,
    CASE_TWO      = 3'd3,
    CASE_DOUBLE   = 3'd4,
    CASE_NO_REAL  = 3'd5
  } case_e;

endpackage

@@ design/quadratic_root_solver_unit.sv @@
// Quadratic root solver: multiply, discriminant, pipelined square root and dividers.
// The square root has one stage per root bit, the dividers one per quotient bit.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Reset clears all stage valid bits; payload registers are not reset.
// The receiver cannot stall: each result is shown for one cycle under valid_o.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COEF_WIDTH-1:0]          coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]          coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]          coef_c_i,
  output logic                                  valid_o,
  output qrs_pkg::case_e                        case_code_o,
  output logic signed [COEF_WIDTH+FRAC_BITS+1:0] root_one_o,
  output logic signed [COEF_WIDTH+FRAC_BITS+1:0] root_two_o
);
  import qrs_pkg::*;

  localparam int W  = COEF_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W + 2;
  localparam int NS = W + 1;
  localparam int RM = NS + 2;
  localparam int NW = W + 2;
  localparam int MW = W + 1;
  localparam int QW = MW + F;
  localparam int RW = QW + 1;

  typedef struct packed {
    case_e                 code;
    logic signed [W:0]     nb;
    logic signed [W:0]     nc;
    logic signed [W:0]     den;
    logic [2*NS-1:0]       x;
    logic [RM-1:0]         rem;
    logic [NS-1:0]         root;
  } sq_t;

  typedef struct packed {
    case_e         code;
    logic          neg1;
    logic          neg2;
    logic [MW-1:0] den;
    logic [QW-1:0] pq1;
    logic [MW-1:0] rem1;
    logic [QW-1:0] pq2;
    logic [MW-1:0] rem2;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t                 r;
    logic [RM+1:0]       rem_t;
    logic [RM+1:0]       trial;
    logic                ge;
    r      = s;
    rem_t  = {s.rem, s.x[2*NS-1 -: 2]};
    trial  = (RM+2)'({s.root, 2'b01});
    ge     = (rem_t >= trial);
    r.rem  = ge ? RM'(rem_t - trial) : RM'(rem_t);
    r.root = {s.root[NS-2:0], ge};
    r.x    = s.x << 2;
    return r;
  endfunction

  function automatic logic [MW+QW-1:0] div_step(input logic [MW-1:0] rem,
                                               input logic [QW-1:0] pq,
                                               input logic [MW-1:0] den);
    logic [MW:0]   rem_t;
    logic          ge;
    logic [MW-1:0] rem_n;
    rem_t = {rem, pq[QW-1]};
    ge    = (rem_t >= {1'b0, den});
    rem_n = ge ? MW'(rem_t - {1'b0, den}) : MW'(rem_t);
    return {rem_n, pq[QW-2:0], ge};
  endfunction

  // stage 1: products
  logic                       v1_q;
  logic signed [W-1:0]        a1_q, b1_q, c1_q;
  logic signed [2*W-1:0]      bb1_q, ac1_q;
  // stage 2: discriminant and case
  logic                       v2_q;
  sq_t                        s2_d;
  logic signed [DW-1:0]       disc;
  // square root stages
  logic [NS:0]                sv_q;
  sq_t                        sq_q [NS+1];
  // numerator stage and divider stages
  logic [QW-1:0]              dvv_q;
  dv_t                        dv_q [QW+1];
  dv_t                        dv_d;
  // output
  logic                       vo_q;
  case_e                      code_q;
  logic signed [RW-1:0]       r1_q, r2_q;

  assign busy = 1'b0;

  always_comb begin
    logic signed [W:0] a_x, b_x, c_x;
    a_x  = {a1_q[W-1], a1_q};
    b_x  = {b1_q[W-1], b1_q};
    c_x  = {c1_q[W-1], c1_q};
    disc = DW'(bb1_q) - (DW'(ac1_q) <<< 2);
    s2_d      = '0;
    s2_d.nb   = -b_x;
    s2_d.nc   = -c_x;
    s2_d.den  = a_x <<< 1;
    s2_d.code = CASE_NO_REAL;
    if (a1_q == '0) begin
      s2_d.den = b_x;
      if (b1_q == '0) begin
        s2_d.code = (c1_q == '0) ? CASE_ALL_X : CASE_NONE;
      end else begin
        s2_d.code = CASE_LINEAR;
      end
    end else if (disc > 0) begin
      s2_d.code = CASE_TWO;
      s2_d.x    = (2*NS)'(disc[DW-2:0]);
    end else if (disc == 0) begin
      s2_d.code = CASE_DOUBLE;
    end
  end

  always_comb begin
    logic signed [NW-1:0] s_x, nb_x, n1, n2;
    logic signed [W:0]    den;
    s_x  = NW'({1'b0, sq_q[NS].root});
    nb_x = {sq_q[NS].nb[W], sq_q[NS].nb};
    den  = sq_q[NS].den;
    n1   = '0;
    n2   = '0;
    unique case (sq_q[NS].code)
      CASE_TWO: begin
        n1 = nb_x + s_x;
        n2 = nb_x - s_x;
      end
      CASE_DOUBLE: n1 = nb_x;
      CASE_LINEAR: n1 = {sq_q[NS].nc[W], sq_q[NS].nc};
      default: den = (W+1)'(1);
    endcase
    dv_d      = '0;
    dv_d.code = sq_q[NS].code;
    dv_d.neg1 = n1[NW-1] ^ den[W];
    dv_d.neg2 = n2[NW-1] ^ den[W];
    dv_d.den  = den[W] ? MW'(-den) : MW'(den);
    dv_d.pq1  = QW'(n1[NW-1] ? MW'(-n1) : MW'(n1)) << F;
    dv_d.pq2  = QW'(n2[NW-1] ? MW'(-n2) : MW'(n2)) << F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      sv_q  <= '0;
      dvv_q <= '0;
      vo_q  <= 1'b0;
    end else begin
      v1_q  <= start;
      v2_q  <= v1_q;
      sv_q  <= {sv_q[NS-1:0], v2_q};
      dvv_q <= {dvv_q[QW-2:0], sv_q[NS]};
      vo_q  <= dvv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [MW+QW-1:0] st1, st2;
    dv_t              nx;
    a1_q     <= coef_a_i;
    b1_q     <= coef_b_i;
    c1_q     <= coef_c_i;
    bb1_q    <= coef_b_i * coef_b_i;
    ac1_q    <= coef_a_i * coef_c_i;
    sq_q[0]  <= s2_d;
    for (int k = 0; k < NS; k++) begin
      sq_q[k+1] <= sqrt_step(sq_q[k]);
    end
    dv_q[0] <= dv_d;
    for (int k = 0; k < QW; k++) begin
      st1     = div_step(dv_q[k].rem1, dv_q[k].pq1, dv_q[k].den);
      st2     = div_step(dv_q[k].rem2, dv_q[k].pq2, dv_q[k].den);
      nx      = dv_q[k];
      nx.rem1 = st1[MW+QW-1 -: MW];
      nx.pq1  = st1[QW-1:0];
      nx.rem2 = st2[MW+QW-1 -: MW];
      nx.pq2  = st2[QW-1:0];
      dv_q[k+1] <= nx;
    end
    code_q <= dv_q[QW].code;
    r1_q   <= dv_q[QW].neg1 ? -$signed({1'b0, dv_q[QW].pq1}) : $signed({1'b0, dv_q[QW].pq1});
    r2_q   <= dv_q[QW].neg2 ? -$signed({1'b0, dv_q[QW].pq2}) : $signed({1'b0, dv_q[QW].pq2});
  end

  assign valid_o     = vo_q;
  assign case_code_o = code_q;
  assign root_one_o  = r1_q;
  assign root_two_o  = r2_q;

endmodule

@@ tb/tb_quadratic_root_solver_unit.sv @@
// Self-checking testbench for the quadratic root solver: random and corner coefficient triples.
module tb_quadratic_root_solver_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int RW = CW + FB + 2;
  localparam int LATENCY = 2 * CW + FB + 6;
  localparam int N_RANDOM = 800;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coefs_t;

  typedef struct packed {
    case_e                code;
    logic signed [RW-1:0] r1;
    logic signed [RW-1:0] r2;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] coef_a_i = '0;
  logic signed [CW-1:0] coef_b_i = '0;
  logic signed [CW-1:0] coef_c_i = '0;
  logic valid_o;
  case_e case_code_o;
  logic signed [RW-1:0] root_one_o;
  logic signed [RW-1:0] root_two_o;

  coefs_t pending_q[$];
  roots_t expected_roots_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int code_seen[6];
  longint cycles = 0;
  bit quiet_phase = 1'b0;
  int gap_left = 0;

  quadratic_root_solver_unit #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .coef_a_i(coef_a_i), .coef_b_i(coef_b_i), .coef_c_i(coef_c_i),
    .valid_o(valid_o), .case_code_o(case_code_o),
    .root_one_o(root_one_o), .root_two_o(root_two_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [RW-1:0] fixed_quotient(longint num, longint den);
    longint unsigned un;
    longint unsigned ud;
    longint q;
    longint lim;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = longint'((un << FB) / ud);
    if ((num < 0) != (den < 0)) q = -q;
    lim = longint'(1) <<< (RW - 1);
    if (q > lim - 1) q = lim - 1;
    if (q < -lim) q = -lim;
    return q[RW-1:0];
  endfunction

  function automatic roots_t solve_roots(coefs_t t);
    roots_t res;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint s;
    a = t.a;
    b = t.b;
    c = t.c;
    res.r1 = '0;
    res.r2 = '0;
    if (a == 0) begin
      if (b == 0) begin
        res.code = (c == 0) ? CASE_ALL_X : CASE_NONE;
      end else begin
        res.code = CASE_LINEAR;
        res.r1 = fixed_quotient(-c, b);
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc > 0) begin
        s = longint'(floor_sqrt(disc));
        res.code = CASE_TWO;
        res.r1 = fixed_quotient(-b + s, 2 * a);
        res.r2 = fixed_quotient(-b - s, 2 * a);
      end else if (disc == 0) begin
        res.code = CASE_DOUBLE;
        res.r1 = fixed_quotient(-b, 2 * a);
      end else begin
        res.code = CASE_NO_REAL;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("tb: mismatch at beat %0d: %s", beats_out, what);
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      4: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_triple(int a, int b, int c);
    coefs_t t;
    t.a = a[CW-1:0];
    t.b = b[CW-1:0];
    t.c = c[CW-1:0];
    pending_q.push_back(t);
  endtask

  always @(negedge clk_i) begin
    logic start_n;
    start_n = start;
    if (rst_ni) begin
      if (start && !busy) begin
        start_n = 1'b0;
        if (!quiet_phase && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
      end
      if (!start_n && gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0 && !start_n) begin
        coefs_t t;
        t = pending_q.pop_front();
        coef_a_i <= t.a;
        coef_b_i <= t.b;
        coef_c_i <= t.c;
        start_n = 1'b1;
      end
    end
    start <= start_n;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && start && !busy) begin
      expected_roots_q.push_back(solve_roots({coef_a_i, coef_b_i, coef_c_i}));
      beats_in++;
    end
    if (rst_ni && valid_o) begin
      roots_t exp_r;
      beats_out++;
      if (expected_roots_q.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        exp_r = expected_roots_q.pop_front();
        code_seen[exp_r.code]++;
        if (case_code_o !== exp_r.code)
          report_mismatch($sformatf("case %0d, want %0d", case_code_o, exp_r.code));
        if (root_one_o !== exp_r.r1)
          report_mismatch($sformatf("root_one %0d, want %0d", root_one_o, exp_r.r1));
        if (root_two_o !== exp_r.r2)
          report_mismatch($sformatf("root_two %0d, want %0d", root_two_o, exp_r.r2));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int tail;
    queue_triple(0, 0, 0);
    queue_triple(0, 0, 5);
    queue_triple(0, 0, -32768);
    queue_triple(0, 3, 7);
    queue_triple(0, -32768, 32767);
    queue_triple(0, 1, -32768);
    queue_triple(0, -1, 32767);
    queue_triple(1, -3, 2);
    queue_triple(1, 2, 1);
    queue_triple(-1, 4, -4);
    queue_triple(1, 0, 1);
    queue_triple(32767, 32767, 32767);
    queue_triple(-32768, -32768, -32768);
    queue_triple(-32768, 32767, 32767);
    queue_triple(1, -32768, -32768);
    queue_triple(1, -32768, 0);
    queue_triple(-1, 32767, 32767);
    queue_triple(2, -2, -12);
    queue_triple(1, 0, -32768);
    queue_triple(-32768, 0, 32767);
    queue_triple(16384, -32768, 16384);
    queue_triple(-1, -1, -1);
    for (int i = 0; i < N_RANDOM; i++) begin
      coefs_t t;
      int k;
      t.a = rand_coef();
      t.b = rand_coef();
      t.c = rand_coef();
      if (i % 8 == 0) begin
        k = int'($urandom_range(0, 40)) - 20;
        t.a = CW'($urandom_range(1, 64));
        t.b = CW'(2 * int'(t.a) * k);
        t.c = CW'(int'(t.a) * k * k);
      end
      pending_q.push_back(t);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() < 100);
    quiet_phase = 1'b1;
    wait (pending_q.size() == 0 && !start);
    wait (expected_roots_q.size() == 0);
    tail = 0;
    while (tail < LATENCY + 10) begin
      @(posedge clk_i);
      tail++;
    end
    $display("tb: %0d triples sent, %0d results checked", beats_in, beats_out);
    $display("tb: cases all/none/linear/two/double/noreal = %0d/%0d/%0d/%0d/%0d/%0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
             code_seen[5]);
    if (errors == 0 && expected_roots_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
